@@ design/tpss_pkg.sv @@
// ----------------------------------------------------------------------------
// Time partition slot scheduler package
// Shared widths, configuration indices, request codes, domain state codes and check codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tpss_pkg;

    localparam int MAX_SLOTS_DEF   = 16;
    localparam int MAX_DOMAINS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_PERIOD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_START  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_SIZE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOTS_IN_USE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_DOMAIN  = 3'd4;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_STATE  = 2'd1;
    localparam logic [1:0] REQ_LOAD   = 2'd2;
    localparam logic [1:0] REQ_VERIFY = 2'd3;

    localparam logic [2:0] DOM_DEAD  = 3'd0;
    localparam logic [2:0] DOM_SLEEP = 3'd1;
    localparam logic [2:0] DOM_READY = 3'd2;
    localparam logic [2:0] DOM_RUN   = 3'd3;
    localparam logic [2:0] DOM_STOP  = 3'd4;

    localparam logic [1:0] CHK_OK       = 2'd0;
    localparam logic [1:0] CHK_ORDER    = 2'd1;
    localparam logic [1:0] CHK_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

@@ design/tpss_if.sv @@
// ----------------------------------------------------------------------------
// Time partition slot scheduler channels
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] tick_time;
    logic [3:0]  target_domain;
    logic [2:0]  new_state;
    logic [3:0]  slot_index;
    logic [15:0] slot_begin;
    logic [15:0] slot_length;
    logic [3:0]  slot_owner;

    modport source (output valid, req_type, tick_time, target_domain, new_state,
                    slot_index, slot_begin, slot_length, slot_owner,
                    input ready);
    modport sink (input valid, req_type, tick_time, target_domain, new_state,
                  slot_index, slot_begin, slot_length, slot_owner,
                  output ready);
endinterface

interface tpss_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] selected_domain;
    logic       domain_found;
    logic [1:0] check_code;
    logic [3:0] bad_slot;

    modport source (output valid, selected_domain, domain_found, check_code, bad_slot,
                    input ready);
    modport sink (input valid, selected_domain, domain_found, check_code, bad_slot,
                  output ready);
endinterface

`default_nettype wire

@@ design/time_partition_slot_scheduler.sv @@
// ----------------------------------------------------------------------------
// Time partition slot scheduler
// Slot table in memory, per-domain state in memory, serial modulo and walk.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), one result per request leaves on res.
// Configuration registers are written through cfg_we/cfg_idx/cfg_data.
// The user must write them only while the block is idle; the block itself
// does not enforce this. A state write or slot load is done when the request
// is taken and goes straight to the result. A verify reads and checks each
// slot in use in turn. A tick runs the bit-serial modulo by the frame period,
// then the window test, then the walk over the slots (read the slot, check
// it, and read the owner's domain state when the slot covers the time).
// One request is handled at a time; a new request is taken once the
// previous result has been loaded into the output register, so a request
// may be taken while that result still waits for the receiver.
// When the receiver stalls, the result holds and at most one more request
// is worked on before the block stops taking requests.
// Reset returns the configuration to its reset values and clears all domain
// states to dead with a sweep over all domains, during which no request
// is taken. The slot table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module time_partition_slot_scheduler
    import tpss_pkg::*;
#(
    parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
    parameter int MAX_DOMAINS = MAX_DOMAINS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    tpss_req_if.sink                      req,
    tpss_res_if.source                    res
);

    localparam int SA_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int DA_BITS = $clog2(MAX_DOMAINS);
    localparam int SC_BITS = $clog2(MAX_SLOTS + 1);
    localparam int TC_BITS = $clog2(TIME_BITS + 1);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_MOD   = 8'b0000_0100,
        ST_WIN   = 8'b0000_1000,
        ST_SRD   = 8'b0001_0000,
        ST_SCHK  = 8'b0010_0000,
        ST_DCHK  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // configuration
    logic [15:0] period_reg, fstart_reg, fsize_reg;
    logic [4:0]  nslots_reg;
    logic [3:0]  idle_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            period_reg <= 16'd1;
            fstart_reg <= '0;
            fsize_reg  <= '0;
            nslots_reg <= '0;
            idle_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_FRAME_PERIOD: period_reg <= cfg_data;
                CFG_FRAME_START:  fstart_reg <= cfg_data;
                CFG_FRAME_SIZE:   fsize_reg  <= cfg_data;
                CFG_SLOTS_IN_USE: nslots_reg <= cfg_data[4:0];
                CFG_IDLE_DOMAIN:  idle_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // memories
    logic [35:0]         slot_mem [MAX_SLOTS];
    logic [2:0]          dom_mem  [MAX_DOMAINS];
    logic                slot_we;
    logic [SA_BITS-1:0]  slot_wa, slot_ra;
    logic [35:0]         slot_wd, slot_rd_reg;
    logic                dom_we;
    logic [DA_BITS-1:0]  dom_wa, dom_ra;
    logic [2:0]          dom_wd, dom_rd_reg;

    always_ff @(posedge clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk) begin
        if (dom_we) begin
            dom_mem[dom_wa] <= dom_wd;
        end
        dom_rd_reg <= dom_mem[dom_ra];
    end

    // control and datapath registers
    state_t                state_reg, state_next;
    logic [DA_BITS:0]      clr_reg, clr_next;
    logic [TIME_BITS-1:0]  tq_reg, tq_next;
    logic [16:0]           rem_reg, rem_next;
    logic [TC_BITS-1:0]    bc_reg, bc_next;
    logic [SC_BITS-1:0]    idx_reg, idx_next;
    logic [SC_BITS-1:0]    nact;
    logic                  is_tick_reg, is_tick_next;
    logic [16:0]           end_reg, end_next;
    logic [3:0]            owner_reg, owner_next;
    logic                  ovld_reg, ovld_next;
    logic [3:0]            sel_reg, sel_next;
    logic                  fnd_reg, fnd_next;
    logic [1:0]            chk_reg, chk_next;
    logic [3:0]            bad_reg, bad_next;
    logic                  rv_reg, rv_next;
    logic [3:0]            o_sel_reg, o_sel_next, o_bad_reg, o_bad_next;
    logic                  o_fnd_reg, o_fnd_next;
    logic [1:0]            o_chk_reg, o_chk_next;

    logic         accept;
    logic [16:0]  rsh, slice_w;
    logic [17:0]  win_end;
    logic [16:0]  sbeg, slen;
    logic [17:0]  send;
    logic [15:0]  s_beg16, s_len16;
    logic [3:0]   s_own;

    assign nact = (32'(nslots_reg) > 32'(MAX_SLOTS)) ? SC_BITS'(MAX_SLOTS)
                                                     : SC_BITS'(nslots_reg);
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign s_beg16 = slot_rd_reg[35:20];
    assign s_len16 = slot_rd_reg[19:4];
    assign s_own   = slot_rd_reg[3:0];
    assign sbeg    = {1'b0, s_beg16};
    assign slen    = {1'b0, s_len16};
    assign send    = {1'b0, sbeg} + {1'b0, slen};
    assign rsh     = {rem_reg[15:0], tq_reg[TIME_BITS-1]};
    assign slice_w = rem_reg - {1'b0, fstart_reg};
    assign win_end = {2'b0, fstart_reg} + {2'b0, fsize_reg};

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        tq_next      = tq_reg;
        rem_next     = rem_reg;
        bc_next      = bc_reg;
        idx_next     = idx_reg;
        is_tick_next = is_tick_reg;
        end_next     = end_reg;
        owner_next   = owner_reg;
        ovld_next    = ovld_reg;
        sel_next     = sel_reg;
        fnd_next     = fnd_reg;
        chk_next     = chk_reg;
        bad_next     = bad_reg;
        rv_next      = rv_reg;
        o_sel_next   = o_sel_reg;
        o_fnd_next   = o_fnd_reg;
        o_chk_next   = o_chk_reg;
        o_bad_next   = o_bad_reg;
        slot_we      = 1'b0;
        slot_wa      = SA_BITS'(req.slot_index);
        slot_wd      = {req.slot_begin, req.slot_length, req.slot_owner};
        slot_ra      = idx_reg[SA_BITS-1:0];
        dom_we       = 1'b0;
        dom_wa       = DA_BITS'(req.target_domain);
        dom_wd       = req.new_state;
        dom_ra       = DA_BITS'(s_own);

        if (rv_reg && res.ready) begin
            rv_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                dom_we   = 1'b1;
                dom_wa   = clr_reg[DA_BITS-1:0];
                dom_wd   = DOM_DEAD;
                clr_next = clr_reg + (DA_BITS+1)'(1);
                if (clr_reg == (DA_BITS+1)'(MAX_DOMAINS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    sel_next = '0;
                    fnd_next = 1'b0;
                    chk_next = CHK_OK;
                    bad_next = '0;
                    idx_next = '0;
                    end_next = '0;
                    case (req.req_type)
                        REQ_TICK: begin
                            is_tick_next = 1'b1;
                            sel_next     = idle_reg;
                            tq_next      = TIME_BITS'(req.tick_time);
                            rem_next     = '0;
                            bc_next      = '0;
                            state_next   = ST_MOD;
                        end
                        REQ_STATE: begin
                            dom_we     = (32'(req.target_domain) < 32'(MAX_DOMAINS));
                            state_next = ST_DONE;
                        end
                        REQ_LOAD: begin
                            slot_we    = (32'(req.slot_index) < 32'(MAX_SLOTS));
                            state_next = ST_DONE;
                        end
                        default: begin
                            is_tick_next = 1'b0;
                            state_next   = ST_SRD;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                // restoring division, one quotient bit per cycle
                if (period_reg == '0) begin
                    rem_next   = 17'(tq_reg);
                    state_next = (TIME_BITS'(17'(tq_reg)) == tq_reg) ? ST_WIN : ST_DONE;
                end else begin
                    tq_next = tq_reg << 1;
                    if (rsh >= {1'b0, period_reg}) begin
                        rem_next = rsh - {1'b0, period_reg};
                    end else begin
                        rem_next = rsh;
                    end
                    bc_next = bc_reg + TC_BITS'(1);
                    if (bc_reg == TC_BITS'(TIME_BITS - 1)) begin
                        state_next = ST_WIN;
                    end
                end
            end
            ST_WIN: begin
                if (rem_reg < {1'b0, fstart_reg} || {1'b0, rem_reg} > win_end) begin
                    state_next = ST_DONE;
                end else begin
                    rem_next   = slice_w;
                    state_next = ST_SRD;
                end
            end
            ST_SRD: begin
                // slot read address issued; data arrives next cycle
                if (idx_reg >= nact) begin
                    if (!is_tick_reg && end_reg > {1'b0, fsize_reg}) begin
                        chk_next = CHK_OVERFLOW;
                    end
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if (is_tick_reg) begin
                    if (rem_reg < sbeg) begin
                        state_next = ST_DONE;
                    end else if ({1'b0, rem_reg} < send) begin
                        owner_next = s_own;
                        ovld_next  = (32'(s_own) < 32'(MAX_DOMAINS));
                        state_next = ST_DCHK;
                    end else begin
                        idx_next   = idx_reg + SC_BITS'(1);
                        state_next = ST_SRD;
                    end
                end else begin
                    if (sbeg < end_reg) begin
                        chk_next   = CHK_ORDER;
                        bad_next   = 4'(idx_reg);
                        state_next = ST_DONE;
                    end else begin
                        end_next   = send[16:0];
                        idx_next   = idx_reg + SC_BITS'(1);
                        state_next = ST_SRD;
                    end
                end
            end
            ST_DCHK: begin
                if (ovld_reg && dom_rd_reg == DOM_READY) begin
                    sel_next   = owner_reg;
                    fnd_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + SC_BITS'(1);
                    state_next = ST_SRD;
                end
            end
            ST_DONE: begin
                if (!rv_reg || res.ready) begin
                    rv_next    = 1'b1;
                    o_sel_next = sel_reg;
                    o_fnd_next = fnd_reg;
                    o_chk_next = chk_reg;
                    o_bad_next = bad_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk) begin
        tq_reg      <= tq_next;
        rem_reg     <= rem_next;
        bc_reg      <= bc_next;
        idx_reg     <= idx_next;
        is_tick_reg <= is_tick_next;
        end_reg     <= end_next;
        owner_reg   <= owner_next;
        ovld_reg    <= ovld_next;
        sel_reg     <= sel_next;
        fnd_reg     <= fnd_next;
        chk_reg     <= chk_next;
        bad_reg     <= bad_next;
        o_sel_reg   <= o_sel_next;
        o_fnd_reg   <= o_fnd_next;
        o_chk_reg   <= o_chk_next;
        o_bad_reg   <= o_bad_next;
    end

    assign res.valid           = rv_reg;
    assign res.selected_domain = o_sel_reg;
    assign res.domain_found    = o_fnd_reg;
    assign res.check_code      = o_chk_reg;
    assign res.bad_slot        = o_bad_reg;

    // A result must not be overwritten while the receiver stalls.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.selected_domain)
            && $stable(res.check_code))
        else $error("result changed while stalled");

    // Requests are taken only outside the reset sweep and the walk.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");

    // A found domain only comes from a tick, never with a verify code.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.domain_found |-> res.check_code == CHK_OK)
        else $error("domain found together with a verify code");

    // The walk never runs past the slots in use.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCHK |-> idx_reg < nact)
        else $error("slot walk out of range");

endmodule

`default_nettype wire
